FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

   // beat type on the request channel
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // token kinds
   localparam logic [3:0] KIND_SEMI     = 4'd0;
   localparam logic [3:0] KIND_VALUE    = 4'd1;
   localparam logic [3:0] KIND_ASSIGN   = 4'd2;
   localparam logic [3:0] KIND_NAND     = 4'd3;
   localparam logic [3:0] KIND_OUT_INT  = 4'd4;
   localparam logic [3:0] KIND_OUT      = 4'd5;
   localparam logic [3:0] KIND_LPAREN   = 4'd6;
   localparam logic [3:0] KIND_RPAREN   = 4'd7;
   localparam logic [3:0] KIND_LBRACK   = 4'd8;
   localparam logic [3:0] KIND_RBRACK   = 4'd9;
   localparam logic [3:0] KIND_LBRACE   = 4'd10;
   localparam logic [3:0] KIND_RBRACE   = 4'd11;
   localparam logic [3:0] KIND_KEYWORD  = 4'd12;
   localparam logic [3:0] KIND_EOF      = 4'd13;
   localparam logic [3:0] KIND_BAD_CHAR = 4'd14;
   localparam logic [3:0] KIND_TOO_LONG = 4'd15;

   // width of the position fields on the result channel
   localparam int POS_OUT_W = 24;
   // enough to index the rows of the largest keyword buffer
   localparam int ROW_IDX_W = 5;
   localparam logic [3:0] CHUNK_FULL = 4'd8;

   // results owed for one accepted beat: an optional pending token or keyword,
   // then an optional token of its own
   typedef struct packed {
      logic                  pre_vld;
      logic [3:0]            pre_kind;
      logic [63:0]           pre_value;
      logic                  word_vld;
      logic [ROW_IDX_W-1:0]  last_row;
      logic [3:0]            last_chars;
      logic [POS_OUT_W-1:0]  pend_line;
      logic [POS_OUT_W-1:0]  pend_col;
      logic                  post_vld;
      logic [3:0]            post_kind;
      logic [POS_OUT_W-1:0]  post_line;
      logic [POS_OUT_W-1:0]  post_col;
   } cst_job_type;

endpackage

FILE: hw/rtl/cst_if.sv
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] ch;

   modport source (output valid, req_type, ch, input ready);
   modport sink (input valid, req_type, ch, output ready);
endinterface

interface cst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [63:0] token_value;
   logic [3:0]  chunk_chars;
   logic [23:0] start_line;
   logic [23:0] start_col;
   logic        last_of_run;

   modport source (output valid, token_kind, token_value, chunk_chars, start_line,
                   start_col, last_of_run, input ready);
   modport sink (input valid, token_kind, token_value, chunk_chars, start_line,
                 start_col, last_of_run, output ready);
endinterface

FILE: hw/rtl/char_stream_tokenizer.sv
// Character stream tokenizer.
// req_bus carries one beat per source character (req_type 0, byte in ch) or an
// end-of-program beat (req_type 1). rsp_bus carries the tokens, each with the
// line and column where it starts; last_of_run marks the final token caused by
// one request beat. Keywords come out as chunks of up to eight packed letters.
// The first token of a request beat passes through the job register, then the
// output register, before it shows on rsp_bus.
// Throughput: one request beat per cycle while rsp_bus takes each token and each
// beat yields at most one token; a beat that yields more holds req_bus.ready low
// until its last token is in the output register, since that register takes one
// token per cycle. A keyword of n letters drains as ceil(n / 8) chunks, one
// word-buffer row read per chunk from the single read port of the buffer memory.
// Reset is synchronous: the scanner returns to idle at line 1, column 1 and no
// token is pending on rsp_bus. The word buffer needs no clearing pass.
// When the receiver stalls, the shown token holds; while no job is in progress,
// beats that yield no token still flow, one more beat that yields tokens is
// taken into the job register, then req_bus.ready drops until it drains.
module char_stream_tokenizer import cst_pkg::*; #(
   parameter int KEYWORD_MAX   = 63,
   parameter int POSITION_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req_bus,
   cst_rsp_if.source  rsp_bus
);

   localparam int ROWS  = (KEYWORD_MAX + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic             req_ready;
   logic             job_free;
   logic             job_vld;
   cst_job_type      job;
   logic             wr_en;
   logic [ROW_W-1:0] wr_row;
   logic [63:0]      wr_data;
   logic             rd_en;
   logic [ROW_W-1:0] rd_row;
   logic [63:0]      rd_data;

   cst_scan #(
      .KEYWORD_MAX   (KEYWORD_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ch    (req_bus.ch),
      .req_ready (req_ready),
      .job_free  (job_free),
      .job_vld   (job_vld),
      .job       (job),
      .wr_en     (wr_en),
      .wr_row    (wr_row),
      .wr_data   (wr_data)
   );

   cst_word_store #(
      .KEYWORD_MAX (KEYWORD_MAX)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   cst_emit #(
      .KEYWORD_MAX (KEYWORD_MAX)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_in_vld  (job_vld),
      .job_in      (job),
      .job_free    (job_free),
      .rd_en       (rd_en),
      .rd_row      (rd_row),
      .rd_data     (rd_data),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .token_kind  (rsp_bus.token_kind),
      .token_value (rsp_bus.token_value),
      .chunk_chars (rsp_bus.chunk_chars),
      .start_line  (rsp_bus.start_line),
      .start_col   (rsp_bus.start_col),
      .last_of_run (rsp_bus.last_of_run)
   );

   assign req_bus.ready = req_ready;

endmodule

FILE: hw/rtl/cst_word_store.sv
module cst_word_store #(
   parameter int KEYWORD_MAX = 63
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [((KEYWORD_MAX + 7) / 8 > 1 ? $clog2((KEYWORD_MAX + 7) / 8) : 1)-1:0] wr_row,
   input  logic [63:0] wr_data,
   input  logic        rd_en,
   input  logic [((KEYWORD_MAX + 7) / 8 > 1 ? $clog2((KEYWORD_MAX + 7) / 8) : 1)-1:0] rd_row,
   output logic [63:0] rd_data
);

   localparam int ROWS = (KEYWORD_MAX + 7) / 8;

   // eight packed characters per row, first character in the low byte
   logic [63:0] mem [ROWS];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cst_scan.sv
module cst_scan import cst_pkg::*; #(
   parameter int KEYWORD_MAX   = 63,
   parameter int POSITION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   input  logic [7:0]  req_ch,
   output logic        req_ready,
   input  logic        job_free,
   output logic        job_vld,
   output cst_job_type job,
   output logic        wr_en,
   output logic [((KEYWORD_MAX + 7) / 8 > 1 ? $clog2((KEYWORD_MAX + 7) / 8) : 1)-1:0] wr_row,
   output logic [63:0] wr_data
);

   localparam int LEN_W = $clog2(KEYWORD_MAX + 1);
   localparam int ROWS  = (KEYWORD_MAX + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_Z      = 8'h7a;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_WORD,
      MODE_GT,
      MODE_ERR
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [63:0]              num_ff, num_in;
   logic [LEN_W-1:0]         wlen_ff, wlen_in;
   logic [63:0]              row_buf_ff, row_buf_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] pline_ff, pline_in;
   logic [POSITION_BITS-1:0] pcol_ff, pcol_in;

   logic                     accept;
   logic                     is_digit;
   logic                     is_lower;
   logic                     is_ws;
   logic                     punct_vld;
   logic [3:0]               punct_kind;
   logic                     consumed;
   logic [63:0]              num_next;
   logic [LEN_W-1:0]         wlen_m1;
   cst_job_type              flush_job;

   function automatic logic [POS_OUT_W-1:0] pos_out(input logic [POSITION_BITS-1:0] v);
      logic [POSITION_BITS+POS_OUT_W-1:0] wide;
      wide = {{POS_OUT_W{1'b0}}, v};
      return wide[POS_OUT_W-1:0];
   endfunction

   function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
      return (v == {POSITION_BITS{1'b1}}) ? v : v + POSITION_BITS'(1);
   endfunction

   assign accept    = req_valid && job_free;
   assign req_ready = job_free;

   assign is_digit = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign is_lower = (req_ch >= CH_A) && (req_ch <= CH_Z);
   assign is_ws    = (req_ch == CH_NL) || (req_ch == CH_SPACE) || (req_ch == CH_TAB);
   // times ten as two shifted adds
   assign num_next = (num_ff << 3) + (num_ff << 1) + 64'(req_ch[3:0]);
   assign wlen_m1  = wlen_ff - LEN_W'(1);

   always_comb begin
      punct_vld  = 1'b1;
      punct_kind = KIND_SEMI;
      unique case (req_ch)
         CH_SEMI:   punct_kind = KIND_SEMI;
         CH_EQ:     punct_kind = KIND_ASSIGN;
         CH_CARET:  punct_kind = KIND_NAND;
         CH_LPAREN: punct_kind = KIND_LPAREN;
         CH_RPAREN: punct_kind = KIND_RPAREN;
         CH_LBRACK: punct_kind = KIND_LBRACK;
         CH_RBRACK: punct_kind = KIND_RBRACK;
         CH_LBRACE: punct_kind = KIND_LBRACE;
         CH_RBRACE: punct_kind = KIND_RBRACE;
         default:   punct_vld = 1'b0;
      endcase
   end

   // what the pending token turns into when something ends it
   always_comb begin
      flush_job            = '0;
      flush_job.pre_vld    = (mode_ff == MODE_NUM) || (mode_ff == MODE_GT);
      flush_job.pre_kind   = (mode_ff == MODE_NUM) ? KIND_VALUE : KIND_OUT;
      flush_job.pre_value  = (mode_ff == MODE_NUM) ? num_ff : 64'd0;
      flush_job.word_vld   = (mode_ff == MODE_WORD);
      flush_job.last_row   = ROW_IDX_W'(wlen_m1 >> 3);
      flush_job.last_chars = {1'b0, wlen_m1[2:0]} + 4'd1;
      flush_job.pend_line  = pos_out(pline_ff);
      flush_job.pend_col   = pos_out(pcol_ff);
   end

   always_comb begin
      mode_in    = mode_ff;
      num_in     = num_ff;
      wlen_in    = wlen_ff;
      row_buf_in = row_buf_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      pline_in   = pline_ff;
      pcol_in    = pcol_ff;
      job        = '0;
      consumed   = 1'b0;
      wr_en      = 1'b0;
      wr_row     = ROW_W'(wlen_ff >> 3);
      // append into the row being filled, a fresh row starts from zero
      wr_data    = (wlen_ff[2:0] == 3'd0) ? {56'd0, req_ch}
                                          : row_buf_ff | (64'(req_ch) << {wlen_ff[2:0], 3'b000});

      if (accept) begin
         if (req_type == REQ_END) begin
            job           = flush_job;
            job.post_vld  = 1'b1;
            job.post_kind = KIND_EOF;
            job.post_line = pos_out(line_ff);
            job.post_col  = pos_out(col_ff);
            mode_in       = MODE_IDLE;
            num_in        = '0;
            wlen_in       = '0;
            line_in       = POSITION_BITS'(1);
            col_in        = POSITION_BITS'(1);
            pline_in      = POSITION_BITS'(1);
            pcol_in       = POSITION_BITS'(1);
         end else if (mode_ff != MODE_ERR) begin
            if (mode_ff == MODE_NUM && is_digit) begin
               num_in   = num_next;
               consumed = 1'b1;
            end else if (mode_ff == MODE_WORD && is_lower) begin
               if (wlen_ff >= LEN_W'(KEYWORD_MAX)) begin
                  job.post_vld  = 1'b1;
                  job.post_kind = KIND_TOO_LONG;
                  job.post_line = pos_out(pline_ff);
                  job.post_col  = pos_out(pcol_ff);
                  wlen_in       = '0;
                  mode_in       = MODE_ERR;
               end else begin
                  wr_en      = 1'b1;
                  row_buf_in = wr_data;
                  wlen_in    = wlen_ff + LEN_W'(1);
               end
               consumed = 1'b1;
            end else if (mode_ff == MODE_GT && req_ch == CH_ZERO) begin
               job.post_vld  = 1'b1;
               job.post_kind = KIND_OUT_INT;
               job.post_line = pos_out(pline_ff);
               job.post_col  = pos_out(pcol_ff);
               mode_in       = MODE_IDLE;
               consumed      = 1'b1;
            end

            if (!consumed) begin
               job     = flush_job;
               mode_in = MODE_IDLE;
               num_in  = '0;
               wlen_in = '0;
               if (is_ws) begin
                  mode_in = MODE_IDLE;
               end else if (punct_vld) begin
                  job.post_vld  = 1'b1;
                  job.post_kind = punct_kind;
                  job.post_line = pos_out(line_ff);
                  job.post_col  = pos_out(col_ff);
               end else begin
                  pline_in = line_ff;
                  pcol_in  = col_ff;
                  if (is_digit) begin
                     mode_in = MODE_NUM;
                     num_in  = 64'(req_ch[3:0]);
                  end else if (is_lower) begin
                     mode_in    = MODE_WORD;
                     wr_en      = 1'b1;
                     wr_row     = '0;
                     wr_data    = {56'd0, req_ch};
                     row_buf_in = {56'd0, req_ch};
                     wlen_in    = LEN_W'(1);
                  end else if (req_ch == CH_GT) begin
                     mode_in = MODE_GT;
                  end else begin
                     job.post_vld  = 1'b1;
                     job.post_kind = KIND_BAD_CHAR;
                     job.post_line = pos_out(line_ff);
                     job.post_col  = pos_out(col_ff);
                     mode_in       = MODE_ERR;
                  end
               end
            end

            if (req_ch == CH_NL) begin
               line_in = pos_inc(line_ff);
               col_in  = POSITION_BITS'(1);
            end else begin
               col_in = pos_inc(col_ff);
            end
         end
      end
   end

   assign job_vld = job.pre_vld || job.word_vld || job.post_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         num_ff   <= '0;
         wlen_ff  <= '0;
         line_ff  <= POSITION_BITS'(1);
         col_ff   <= POSITION_BITS'(1);
         pline_ff <= POSITION_BITS'(1);
         pcol_ff  <= POSITION_BITS'(1);
      end else begin
         mode_ff  <= mode_in;
         num_ff   <= num_in;
         wlen_ff  <= wlen_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         pline_ff <= pline_in;
         pcol_ff  <= pcol_in;
      end
   end

   always_ff @(posedge clock) begin
      row_buf_ff <= row_buf_in;
   end

endmodule

FILE: hw/rtl/cst_emit.sv
module cst_emit import cst_pkg::*; #(
   parameter int KEYWORD_MAX = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_in_vld,
   input  cst_job_type job_in,
   output logic        job_free,
   output logic        rd_en,
   output logic [((KEYWORD_MAX + 7) / 8 > 1 ? $clog2((KEYWORD_MAX + 7) / 8) : 1)-1:0] rd_row,
   input  logic [63:0] rd_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [3:0]  token_kind,
   output logic [63:0] token_value,
   output logic [3:0]  chunk_chars,
   output logic [POS_OUT_W-1:0] start_line,
   output logic [POS_OUT_W-1:0] start_col,
   output logic        last_of_run
);

   localparam int ROWS  = (KEYWORD_MAX + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_PRE,
      EM_WORD,
      EM_POST
   } em_state_type;

   em_state_type         state_ff, state_in;
   cst_job_type          job_ff;
   logic [ROW_W-1:0]     rd_row_ff;
   logic                 rsp_vld_ff;
   logic [3:0]           kind_ff;
   logic [63:0]          value_ff;
   logic [3:0]           chunk_ff;
   logic [POS_OUT_W-1:0] line_ff;
   logic [POS_OUT_W-1:0] col_ff;
   logic                 last_ff;

   logic                 out_free;
   logic                 emit_now;
   logic                 at_last;
   logic                 cur_last;
   logic [3:0]           cur_kind;
   logic [63:0]          cur_value;
   logic [3:0]           cur_chunk;
   logic [POS_OUT_W-1:0] cur_line;
   logic [POS_OUT_W-1:0] cur_col;
   em_state_type         start_state;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign at_last  = (rd_row_ff == job_ff.last_row[ROW_W-1:0]);

   always_comb begin
      cur_kind  = KIND_EOF;
      cur_value = '0;
      cur_chunk = '0;
      cur_line  = job_ff.pend_line;
      cur_col   = job_ff.pend_col;
      cur_last  = 1'b0;
      state_in  = EM_IDLE;
      unique case (state_ff)
         EM_PRE: begin
            cur_kind  = job_ff.pre_kind;
            cur_value = job_ff.pre_value;
            cur_last  = !job_ff.post_vld;
            state_in  = job_ff.post_vld ? EM_POST : EM_IDLE;
         end
         EM_WORD: begin
            cur_kind  = KIND_KEYWORD;
            cur_value = rd_data;
            cur_chunk = at_last ? job_ff.last_chars : CHUNK_FULL;
            cur_last  = at_last && !job_ff.post_vld;
            if (!at_last) begin
               state_in = EM_WORD;
            end else if (job_ff.post_vld) begin
               state_in = EM_POST;
            end else begin
               state_in = EM_IDLE;
            end
         end
         EM_POST: begin
            cur_kind = job_ff.post_kind;
            cur_line = job_ff.post_line;
            cur_col  = job_ff.post_col;
            cur_last = 1'b1;
            state_in = EM_IDLE;
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   assign emit_now = (state_ff != EM_IDLE) && out_free;
   assign job_free = (state_ff == EM_IDLE) || (emit_now && cur_last);

   always_comb begin
      if (job_in.pre_vld) begin
         start_state = EM_PRE;
      end else if (job_in.word_vld) begin
         start_state = EM_WORD;
      end else begin
         start_state = EM_POST;
      end
   end

   // row 0 is fetched as the job loads, each shown chunk fetches the next row
   assign rd_en  = (job_in_vld && job_in.word_vld)
                || (emit_now && state_ff == EM_WORD && !at_last);
   assign rd_row = job_in_vld ? '0 : rd_row_ff + ROW_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= EM_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (emit_now) begin
            rsp_vld_ff <= 1'b1;
            kind_ff    <= cur_kind;
            value_ff   <= cur_value;
            chunk_ff   <= cur_chunk;
            line_ff    <= cur_line;
            col_ff     <= cur_col;
            last_ff    <= cur_last;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end

         if (job_in_vld) begin
            job_ff    <= job_in;
            rd_row_ff <= '0;
            state_ff  <= start_state;
         end else if (emit_now) begin
            state_ff <= state_in;
            if (state_ff == EM_WORD && !at_last) begin
               rd_row_ff <= rd_row_ff + ROW_W'(1);
            end
         end
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign token_kind  = kind_ff;
   assign token_value = value_ff;
   assign chunk_chars = chunk_ff;
   assign start_line  = line_ff;
   assign start_col   = col_ff;
   assign last_of_run = last_ff;

endmodule

FILE: hw/rtl/cst_checker.sv
module cst_checker import cst_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  token_kind,
   input logic [63:0] token_value,
   input logic [3:0]  chunk_chars,
   input logic [23:0] start_line,
   input logic [23:0] start_col,
   input logic        last_of_run
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind)
         && $stable(token_value) && $stable(chunk_chars) && $stable(start_line)
         && $stable(start_col) && $stable(last_of_run))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind != KIND_KEYWORD |-> chunk_chars == 4'd0)
      else $error("chunk count on a non-keyword token");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == KIND_KEYWORD |-> chunk_chars != 4'd0
         && chunk_chars <= CHUNK_FULL)
      else $error("keyword chunk count out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind != KIND_KEYWORD && token_kind != KIND_VALUE
         |-> token_value == 64'd0)
      else $error("value on a token that carries none");

   // end of program always closes the run of its beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == KIND_EOF |-> last_of_run)
      else $error("eof not last of run");

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .token_kind  (rsp_bus.token_kind),
   .token_value (rsp_bus.token_value),
   .chunk_chars (rsp_bus.chunk_chars),
   .start_line  (rsp_bus.start_line),
   .start_col   (rsp_bus.start_col),
   .last_of_run (rsp_bus.last_of_run)
);
